// ===== hdl/crcfr_pkg.sv =====
// shared types, constants and the byte-wise crc-32 step for the frame receiver
package crcfr_pkg;

  localparam int BUF_SIZE = 512;
  localparam int BUF_AW   = $clog2(BUF_SIZE);
  localparam int CNT_W    = $clog2(BUF_SIZE + 1);

  localparam int FRAME_MIN_LEN = 6;
  localparam int CRC_TAIL_LEN  = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] OPCODE_MIN_RST = 8'd1;
  localparam logic [7:0] OPCODE_MAX_RST = 8'd6;

  typedef enum logic [1:0] {
    FUNC_DATA = 2'd0,
    FUNC_EOF  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic {
    REG_OPCODE_MIN = 1'b0,
    REG_OPCODE_MAX = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        frame_ok;
    logic [7:0]  opcode;
    logic [7:0]  sequence_res;
    logic [8:0]  body_length;
    logic [31:0] dropped_count;
    logic        rd_hit;
  } res_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/crcfr_buffer.sv =====
// frame byte memory, one write port and one registered read port
module crcfr_buffer (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [crcfr_pkg::BUF_AW-1:0] wr_addr_i,
  input  logic [7:0]                 wr_data_i,
  input  logic                       rd_en_i,
  input  logic [crcfr_pkg::BUF_AW-1:0] rd_addr_i,
  output logic [7:0]                 rd_data_o
);
  import crcfr_pkg::*;

  logic [7:0] mem [BUF_SIZE];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/crcfr_frame_ctrl.sv =====
// frame state: byte count, crc, tail bytes, drop counter, opcode range registers and frame checks
module crcfr_frame_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  crcfr_pkg::func_e             func_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [8:0]                   read_index_i,
  input  logic                         cfg_we_i,
  input  crcfr_pkg::cfg_reg_e          cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  output logic                         wr_en_o,
  output logic [crcfr_pkg::BUF_AW-1:0] wr_addr_o,
  output logic                         rd_en_o,
  output logic [crcfr_pkg::BUF_AW-1:0] rd_addr_o,
  output logic                         res_valid_o,
  output crcfr_pkg::res_t              res_o
);
  import crcfr_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             skip_q, skip_d;
  logic [31:0]      drop_q, drop_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      tail_q, tail_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       second_q, second_d;
  logic [7:0]       op_min_q, op_max_q;
  logic             full;
  logic             frame_ok;

  assign full     = (count_q == CNT_W'(BUF_SIZE));
  assign frame_ok = (count_q >= CNT_W'(FRAME_MIN_LEN)) && ((crc_q ^ CRC_INIT) == tail_q) &&
                    (first_q >= op_min_q) && (first_q <= op_max_q);

  assign wr_en_o   = accept_i && (func_i == FUNC_DATA) && !skip_q && !full;
  assign wr_addr_o = count_q[BUF_AW-1:0];
  assign rd_en_o   = accept_i && (func_i == FUNC_READ);
  assign rd_addr_o = BUF_AW'(read_index_i);

  always_comb begin
    count_d     = count_q;
    skip_d      = skip_q;
    drop_d      = drop_q;
    crc_d       = crc_q;
    tail_d      = tail_q;
    first_d     = first_q;
    second_d    = second_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (func_i)
        FUNC_DATA: begin
          if (!skip_q) begin
            if (full) begin
              drop_d  = drop_q + 32'd1;
              skip_d  = 1'b1;
              count_d = '0;
              crc_d   = CRC_INIT;
              tail_d  = '0;
            end else begin
              if (count_q >= CNT_W'(CRC_TAIL_LEN)) begin
                crc_d = crc32_byte(crc_q, tail_q[7:0]);
              end
              tail_d  = {data_byte_i, tail_q[31:8]};
              count_d = count_q + CNT_W'(1);
              if (count_q == CNT_W'(0)) begin
                first_d = data_byte_i;
              end
              if (count_q == CNT_W'(1)) begin
                second_d = data_byte_i;
              end
            end
          end
        end
        FUNC_EOF: begin
          if (skip_q) begin
            skip_d = 1'b0;
          end else if (count_q != '0) begin
            if (!frame_ok) begin
              drop_d = drop_q + 32'd1;
            end
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_REPORT;
            res_o.frame_ok     = frame_ok;
            res_o.opcode       = first_q;
            res_o.sequence_res = (count_q >= CNT_W'(2)) ? second_q : 8'd0;
            res_o.body_length  = frame_ok ? 9'(count_q - CNT_W'(FRAME_MIN_LEN)) : 9'd0;
            res_o.dropped_count = drop_d;
          end
          count_d = '0;
          crc_d   = CRC_INIT;
          tail_d  = '0;
        end
        FUNC_READ: begin
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_READ;
          res_o.rd_hit = (32'(read_index_i) < 32'(BUF_SIZE));
        end
        FUNC_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      skip_q  <= 1'b0;
      drop_q  <= '0;
      crc_q   <= CRC_INIT;
      tail_q  <= '0;
    end else begin
      count_q <= count_d;
      skip_q  <= skip_d;
      drop_q  <= drop_d;
      crc_q   <= crc_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_min_q <= OPCODE_MIN_RST;
      op_max_q <= OPCODE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OPCODE_MIN: op_min_q <= cfg_data_i;
        REG_OPCODE_MAX: op_max_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/crcfr_out_reg.sv =====
// result register on the output channel
module crcfr_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  crcfr_pkg::res_t res_i,
  input  logic            out_ready_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  output crcfr_pkg::res_t res_o
);
  import crcfr_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/crc_checked_frame_receiver_unit.sv =====
// top level of the crc-checked frame receiver
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_ready_o   func_i, data_byte_i, read_index_i
//  out      source     out_valid_o / out_ready_i result_kind_o .. read_byte_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle while in_ready_o is high; a result is registered and appears in the cycle after its transfer
// the buffer read port is registered and drives read_byte_o directly, beside the output register
// in_ready_o drops only while a result waits in the output register and out_ready_i is low
// reset clears frame state, drop counter and opcode range; buffer contents are undefined
module crc_checked_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [8:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic        frame_ok_o,
  output logic [7:0]  opcode_o,
  output logic [7:0]  sequence_res_o,
  output logic [8:0]  body_length_o,
  output logic [31:0] dropped_count_o,
  output logic [7:0]  read_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import crcfr_pkg::*;

  logic              accept;
  logic              wr_en, rd_en;
  logic [BUF_AW-1:0] wr_addr, rd_addr;
  logic [7:0]        rd_data;
  logic              res_valid;
  res_t              res, res_q;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  crcfr_frame_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (func_e'(func_i)),
    .data_byte_i  (data_byte_i),
    .read_index_i (read_index_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  crcfr_buffer u_buffer (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (data_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  crcfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .res_o       (res_q)
  );

  assign result_kind_o   = res_q.kind;
  assign frame_ok_o      = res_q.frame_ok;
  assign opcode_o        = res_q.opcode;
  assign sequence_res_o  = res_q.sequence_res;
  assign body_length_o   = res_q.body_length;
  assign dropped_count_o = res_q.dropped_count;
  assign read_byte_o     = ((res_q.kind == KIND_READ) && res_q.rd_hit) ? rd_data : 8'd0;

endmodule

// ===== hdl/crcfr_checker.sv =====
// port-level checks on the frame receiver, bound to the top level
module crcfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        result_kind_o,
  input logic        frame_ok_o,
  input logic [7:0]  opcode_o,
  input logic [7:0]  sequence_res_o,
  input logic [8:0]  body_length_o,
  input logic [31:0] dropped_count_o,
  input logic [7:0]  read_byte_o
);
  import crcfr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o) &&
    $stable(dropped_count_o))
    else $error("result dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_READ) |->
    !frame_ok_o && (opcode_o == 8'd0) && (sequence_res_o == 8'd0) &&
    (body_length_o == 9'd0) && (dropped_count_o == 32'd0))
    else $error("read result carries report fields");

  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_REPORT) |->
    (read_byte_o == 8'd0) && (frame_ok_o || (body_length_o == 9'd0)))
    else $error("frame report carries stray fields");

endmodule

bind crc_checked_frame_receiver_unit crcfr_checker u_crcfr_checker (.*);

// ===== test/tb_top.sv =====
// testbench for the crc-checked frame receiver: random framed byte streams and buffer reads
module tb_top;
  import crcfr_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic [7:0]  opcode;
    logic [7:0]  seq;
    logic [8:0]  blen;
    logic [31:0] drops;
    logic [7:0]  rbyte;
  } reply_t;

  typedef struct packed {
    func_e      func;
    logic [7:0] data;
    logic [8:0] idx;
    logic       has_reply;
    reply_t     reply;
  } symbol_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  func_e       in_func = FUNC_DATA;
  logic [7:0]  in_data = '0;
  logic [8:0]  in_idx = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        res_kind;
  logic        res_ok;
  logic [7:0]  res_opcode;
  logic [7:0]  res_seq;
  logic [8:0]  res_blen;
  logic [31:0] res_drops;
  logic [7:0]  res_rbyte;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_e    cfg_index = REG_OPCODE_MIN;
  logic [7:0]  cfg_data = '0;

  // predictor state
  logic [7:0]  frame_img [BUF_SIZE];
  int          nbytes;
  int          fill_hwm;
  bit          skip;
  logic [31:0] crc_acc;
  logic [31:0] tail;
  logic [31:0] drops;
  logic [7:0]  op_lo;
  logic [7:0]  op_hi;

  symbol_t     symbol_q [$];
  reply_t      owed_replies [$];
  symbol_t     sym_cur;
  int          n_pushed = 0;
  int          n_taken = 0;
  int          n_items = 0;
  int          err_count = 0;
  int          tx_gap = 0;
  bit          tx_quiet = 1'b0;
  int          rx_wait = 0;
  bit          rx_quiet = 1'b0;
  bit          long_hold_done = 1'b0;

  crc_checked_frame_receiver_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (in_func),
    .data_byte_i     (in_data),
    .read_index_i    (in_idx),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_kind_o   (res_kind),
    .frame_ok_o      (res_ok),
    .opcode_o        (res_opcode),
    .sequence_res_o  (res_seq),
    .body_length_o   (res_blen),
    .dropped_count_o (res_drops),
    .read_byte_o     (res_rbyte),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[k]}});
    end
    return c;
  endfunction

  function automatic void restart_frame();
    nbytes  = 0;
    crc_acc = CRC_INIT;
    tail    = '0;
  endfunction

  function automatic bit receiver_step(input func_e f, input logic [7:0] d,
                                       input logic [8:0] ix, output reply_t r);
    logic ok;
    r = '0;
    r.kind = KIND_REPORT;
    case (f)
      FUNC_DATA: begin
        if (skip) return 1'b0;
        if (nbytes >= BUF_SIZE) begin
          drops++;
          skip = 1'b1;
          restart_frame();
          return 1'b0;
        end
        if (nbytes >= CRC_TAIL_LEN) crc_acc = crc32_update(crc_acc, tail[7:0]);
        tail = {d, tail[31:8]};
        frame_img[nbytes] = d;
        nbytes++;
        if (nbytes > fill_hwm) fill_hwm = nbytes;
        return 1'b0;
      end
      FUNC_EOF: begin
        if (skip) begin
          skip = 1'b0;
          restart_frame();
          return 1'b0;
        end
        if (nbytes == 0) return 1'b0;
        r.opcode = frame_img[0];
        r.seq    = (nbytes >= 2) ? frame_img[1] : 8'd0;
        ok = (nbytes >= FRAME_MIN_LEN) && (~crc_acc == tail) &&
             (frame_img[0] >= op_lo) && (frame_img[0] <= op_hi);
        if (!ok) drops++;
        r.ok    = ok;
        r.blen  = ok ? 9'(nbytes - FRAME_MIN_LEN) : 9'd0;
        r.drops = drops;
        restart_frame();
        return 1'b1;
      end
      FUNC_READ: begin
        r.kind  = KIND_READ;
        r.rbyte = frame_img[ix];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_item(input func_e f, input logic [7:0] d, input logic [8:0] ix);
    symbol_t s;
    s.func = f;
    s.data = d;
    s.idx  = ix;
    s.has_reply = receiver_step(f, d, ix, s.reply);
    symbol_q.push_back(s);
    n_pushed++;
    if (f != FUNC_NONE) n_items++;
  endtask

  // only entries written since reset are read back
  task automatic push_read();
    if (fill_hwm > 0) push_item(FUNC_READ, 8'($urandom), 9'($urandom_range(0, fill_hwm - 1)));
  endtask

  task automatic push_frame(input int len, input logic [7:0] op, input bit good_crc);
    logic [7:0]  fb [$];
    logic [31:0] c;
    int          pos;
    for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
    if (len >= 1) fb[0] = op;
    if (len >= FRAME_MIN_LEN) begin
      c = CRC_INIT;
      for (int i = 0; i < len - CRC_TAIL_LEN; i++) c = crc32_update(c, fb[i]);
      c = ~c;
      for (int i = 0; i < CRC_TAIL_LEN; i++) fb[len - CRC_TAIL_LEN + i] = c[8*i +: 8];
      if (!good_crc) begin
        pos = $urandom_range(0, len - 1);
        fb[pos] = fb[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) push_read();
      push_item(FUNC_DATA, fb[i], 9'($urandom));
    end
    push_item(FUNC_EOF, 8'($urandom), 9'($urandom));
  endtask

  task automatic random_traffic(input int n_target);
    int         stop;
    int         pick;
    int         len;
    logic [7:0] op;
    func_e      f;
    stop = n_items + n_target;
    while (n_items < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(0, 199);
        if (len == 0) len = $urandom_range(300, BUF_SIZE);
        else if (len == 1) len = $urandom_range(BUF_SIZE + 1, BUF_SIZE + 6);
        else if (len < 14) len = $urandom_range(0, FRAME_MIN_LEN - 1);
        else len = $urandom_range(FRAME_MIN_LEN, 24);
        if (op_lo <= op_hi && $urandom_range(0, 3) != 0) op = 8'($urandom_range(op_lo, op_hi));
        else op = 8'($urandom);
        push_frame(len, op, $urandom_range(0, 9) != 0);
      end else if (pick < 90) begin
        push_read();
      end else begin
        f = func_e'($urandom_range(0, 3));
        if (f == FUNC_READ) push_read();
        else push_item(f, 8'($urandom), 9'($urandom));
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk); while (n_taken != n_pushed || owed_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (which == REG_OPCODE_MIN) op_lo = value;
    else op_hi = value;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  task automatic check_reply(input reply_t e);
    cmp_field("result_kind", e.kind, res_kind);
    cmp_field("frame_ok", e.ok, res_ok);
    cmp_field("opcode", e.opcode, res_opcode);
    cmp_field("sequence_res", e.seq, res_seq);
    cmp_field("body_length", e.blen, res_blen);
    cmp_field("dropped_count", e.drops, res_drops);
    cmp_field("read_byte", e.rbyte, res_rbyte);
  endtask

  // input driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_taken++;
        if (sym_cur.has_reply) owed_replies.push_back(sym_cur.reply);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (symbol_q.size() > 0) begin
          sym_cur = symbol_q.pop_front();
          in_valid <= 1'b1;
          in_func  <= sym_cur.func;
          in_data  <= sym_cur.data;
          in_idx   <= sym_cur.idx;
          tx_gap = tx_quiet ? 0 : $urandom_range(0, 14);
          if ($urandom_range(0, 99) == 0) tx_quiet = !tx_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          $error("result transfer with nothing outstanding");
          err_count++;
        end else begin
          check_reply(owed_replies.pop_front());
        end
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
        // one long hold-off while the sender still has plenty queued
        if (!long_hold_done && symbol_q.size() > 60) begin
          rx_wait += 400;
          long_hold_done = 1'b1;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[crc_checked_frame_receiver_unit] ERROR");
    $finish;
  end

  initial begin
    logic [7:0] lo;
    logic [7:0] hi;
    restart_frame();
    fill_hwm = 0;
    skip     = 1'b0;
    drops    = '0;
    op_lo    = OPCODE_MIN_RST;
    op_hi    = OPCODE_MAX_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset opcode range
    push_item(FUNC_EOF, 8'h00, 9'h000);
    push_item(FUNC_NONE, 8'hff, 9'h1ff);
    push_frame(1, 8'h03, 1'b1);
    push_item(FUNC_READ, 8'hff, 9'h000);
    push_frame(FRAME_MIN_LEN, OPCODE_MIN_RST, 1'b1);
    push_frame(FRAME_MIN_LEN, OPCODE_MAX_RST, 1'b1);
    push_frame(FRAME_MIN_LEN, 8'h00, 1'b1);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin lo = 8'd0;   hi = 8'd255; end
        1: begin lo = 8'd0;   hi = 8'd0;   end
        2: begin lo = 8'd255; hi = 8'd255; end
        3: begin lo = 8'd200; hi = 8'd10;  end
        default: begin lo = 8'($urandom_range(0, 100)); hi = 8'($urandom_range(100, 255)); end
      endcase
      write_reg(REG_OPCODE_MIN, lo);
      write_reg(REG_OPCODE_MAX, hi);
      if (p == 0) begin
        push_frame(BUF_SIZE, 8'($urandom), 1'b1);
        push_frame(BUF_SIZE + 3, 8'($urandom), 1'b1);
      end
      random_traffic(90);
      drain();
    end

    if (err_count == 0) begin
      $display("[crc_checked_frame_receiver_unit] OK");
    end else begin
      $display("[crc_checked_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule
